/* src/ilff_pkg.sv */
package ilff_pkg;

    localparam int unsigned HEAP_WORDS_DEFAULT = 4096;
    localparam logic [14:0] LIMIT_RESET = 15'd16384;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_IGN = 2'd2;

    localparam logic [31:0] TAG_USED      = 32'h1;
    localparam logic [31:0] BLOCK_SZ_MASK = 32'hFFFF_FFF8;

endpackage

/* src/ilff_ram.sv */
module ilff_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* src/implicit_list_first_fit_allocator.sv */
// First-fit heap allocator with boundary tags over a single-port word RAM.
// Input channel: pulse start with req_type, request_bytes and payload_address
// while busy is low; the item is taken at that clock edge and busy rises.
// Result channel: done is high for exactly one cycle with result_address and
// status (0 ok, 1 out of memory, 2 free ignored). The receiver cannot stall;
// a result must be captured in the cycle that done is high.
// Using the one RAM port, an allocate reads and checks each block it passes,
// then writes header and footer for an exact fit, plus the rest's for a split,
// or header, footer and epilogue to grow the heap, or reports out of memory.
// A free reads its header and neighbour tags, then writes the merged header
// and footer. One item is worked on at a time; busy falls in the cycle that
// done is high, so the next item can be taken at the edge that ends that cycle.
// Configuration: heap_limit_we writes heap_limit_bytes; the user must write
// it only while idle; the block does not enforce this. Reset: the limit returns
// to 16384 and the heap break to byte 4; once out of reset the block writes the
// prologue and epilogue words, with busy high, before it takes the first item.
module implicit_list_first_fit_allocator #(
    parameter int unsigned HEAP_WORDS = ilff_pkg::HEAP_WORDS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [13:0] request_bytes,
    input  logic [13:0] payload_address,
    output logic        done,
    output logic [13:0] result_address,
    output logic [1:0]  status,
    input  logic        heap_limit_we,
    input  logic [14:0] heap_limit_bytes
);

    localparam int unsigned AW = $clog2(HEAP_WORDS);
    localparam logic [33:0] CAP_BYTES = 34'(HEAP_WORDS) * 34'd4;

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE, S_WALK_RD, S_WALK_CHK, S_SPL1, S_SPL2, S_SPL3,
        S_TAIL_CHK, S_GROW1, S_GROW2, S_FR_HDR, S_FR_NXT, S_FR_PRV, S_FR_W2
    } state_t;

    state_t      state_reg, state_next;
    logic [32:0] h_reg, h_next;
    logic [14:0] need_reg, need_next;
    logic [14:0] brk_reg, brk_next;
    logic [14:0] limit_reg, limit_next;
    logic [31:0] sz_reg, sz_next;
    logic [31:0] nw_reg, nw_next;
    logic [31:0] wa_reg, wa_next;
    logic [31:0] wv_reg, wv_next;
    logic        done_reg, done_next;
    logic [13:0] addr_reg, addr_next;
    logic [1:0]  status_reg, status_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;

    logic [14:0] lim;
    logic [31:0] rsz, nsz, psz, a1, a2, vsum, lsz_ext;
    logic [14:0] lsz, start_b, grow, nb;
    logic [16:0] total;
    logic [31:0] need32;

    function automatic logic [AW-1:0] wi(input logic [32:0] x);
        return x[AW+1:2];
    endfunction

    ilff_ram #(
        .WIDTH(32),
        .DEPTH(HEAP_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        lim = (CAP_BYTES < {19'd0, limit_reg}) ? CAP_BYTES[14:0] : limit_reg;
        need32 = {17'd0, need_reg};
        rsz = ram_rdata & ilff_pkg::BLOCK_SZ_MASK;
        nsz = nw_reg & ilff_pkg::BLOCK_SZ_MASK;
        psz = rsz;
        lsz_ext = rsz;
        lsz = rsz[14:0];
        if (!ram_rdata[0] && (lsz_ext < need32)
            && ({1'b0, lsz_ext} + 33'd4 <= {18'd0, brk_reg}))
        begin
            start_b = brk_reg - lsz;
            grow = need_reg - lsz;
        end
        else
        begin
            start_b = brk_reg;
            grow = need_reg;
        end
        total = {2'd0, brk_reg} + {2'd0, grow} + 17'd4;
        nb = start_b + need_reg;
        a1 = ram_rdata[0] ? wa_reg : wa_reg - psz;
        a2 = nw_reg[0] ? (wa_reg + sz_reg - 32'd4) : (wa_reg + sz_reg + nsz - 32'd4);
        vsum = sz_reg + (ram_rdata[0] ? 32'd0 : psz) + (nw_reg[0] ? 32'd0 : nsz);

        state_next = state_reg;
        h_next = h_reg;
        need_next = need_reg;
        brk_next = brk_reg;
        limit_next = heap_limit_we ? heap_limit_bytes : limit_reg;
        sz_next = sz_reg;
        nw_next = nw_reg;
        wa_next = wa_reg;
        wv_next = wv_reg;
        done_next = 1'b0;
        addr_next = addr_reg;
        status_next = status_reg;
        ram_we = 1'b0;
        ram_addr = '0;
        ram_wdata = '0;

        unique case (state_reg)
            S_INIT0:
            begin
                ram_we = 1'b1;
                ram_addr = wi(33'd0);
                ram_wdata = ilff_pkg::TAG_USED;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                ram_we = 1'b1;
                ram_addr = wi(33'd4);
                ram_wdata = ilff_pkg::TAG_USED;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == ilff_pkg::REQ_ALLOC)
                    begin
                        need_next = ({1'b0, request_bytes} + 15'd15) & ~15'd7;
                        h_next = 33'd4;
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        wa_next = {18'd0, payload_address} - 32'd4;
                        ram_addr = wi({1'b0, wa_next});
                        state_next = S_FR_HDR;
                    end
                end
            end
            S_WALK_RD:
            begin
                if (h_reg < {18'd0, brk_reg})
                begin
                    ram_addr = wi(h_reg);
                    state_next = S_WALK_CHK;
                end
                else
                begin
                    ram_addr = wi({18'd0, brk_reg} - 33'd4);
                    state_next = S_TAIL_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (rsz == 32'd0)
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    status_next = ilff_pkg::ST_OOM;
                    state_next = S_IDLE;
                end
                else if (!ram_rdata[0] && rsz >= need32)
                begin
                    ram_we = 1'b1;
                    ram_addr = wi(h_reg);
                    ram_wdata = need32 | ilff_pkg::TAG_USED;
                    sz_next = rsz;
                    state_next = S_SPL1;
                end
                else
                begin
                    h_next = h_reg + {1'b0, rsz};
                    state_next = S_WALK_RD;
                end
            end
            S_SPL1:
            begin
                ram_we = 1'b1;
                ram_addr = wi(h_reg + {1'b0, need32} - 33'd4);
                ram_wdata = need32 | ilff_pkg::TAG_USED;
                if (sz_reg != need32)
                begin
                    state_next = S_SPL2;
                end
                else
                begin
                    done_next = 1'b1;
                    addr_next = h_reg[13:0] + 14'd4;
                    status_next = ilff_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            S_SPL2:
            begin
                ram_we = 1'b1;
                ram_addr = wi(h_reg + {1'b0, need32});
                ram_wdata = sz_reg - need32;
                state_next = S_SPL3;
            end
            S_SPL3:
            begin
                ram_we = 1'b1;
                ram_addr = wi(h_reg + {1'b0, sz_reg} - 33'd4);
                ram_wdata = sz_reg - need32;
                done_next = 1'b1;
                addr_next = h_reg[13:0] + 14'd4;
                status_next = ilff_pkg::ST_OK;
                state_next = S_IDLE;
            end
            S_TAIL_CHK:
            begin
                if (total > {2'd0, lim})
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    status_next = ilff_pkg::ST_OOM;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_we = 1'b1;
                    ram_addr = wi({18'd0, start_b});
                    ram_wdata = need32 | ilff_pkg::TAG_USED;
                    wa_next = {17'd0, nb};
                    h_next = {18'd0, start_b};
                    state_next = S_GROW1;
                end
            end
            S_GROW1:
            begin
                ram_we = 1'b1;
                ram_addr = wi({1'b0, wa_reg} - 33'd4);
                ram_wdata = need32 | ilff_pkg::TAG_USED;
                state_next = S_GROW2;
            end
            S_GROW2:
            begin
                ram_we = 1'b1;
                ram_addr = wi({1'b0, wa_reg});
                ram_wdata = ilff_pkg::TAG_USED;
                brk_next = wa_reg[14:0];
                done_next = 1'b1;
                addr_next = h_reg[13:0] + 14'd4;
                status_next = ilff_pkg::ST_OK;
                state_next = S_IDLE;
            end
            S_FR_HDR:
            begin
                if (!ram_rdata[0])
                begin
                    done_next = 1'b1;
                    addr_next = '0;
                    status_next = ilff_pkg::ST_IGN;
                    state_next = S_IDLE;
                end
                else
                begin
                    sz_next = rsz;
                    ram_addr = wi({1'b0, wa_reg + rsz});
                    state_next = S_FR_NXT;
                end
            end
            S_FR_NXT:
            begin
                nw_next = ram_rdata;
                ram_addr = wi({1'b0, wa_reg - 32'd4});
                state_next = S_FR_PRV;
            end
            S_FR_PRV:
            begin
                ram_we = 1'b1;
                ram_addr = wi({1'b0, a1});
                ram_wdata = vsum;
                wa_next = a2;
                wv_next = vsum;
                state_next = S_FR_W2;
            end
            S_FR_W2:
            begin
                ram_we = 1'b1;
                ram_addr = wi({1'b0, wa_reg});
                ram_wdata = wv_reg;
                done_next = 1'b1;
                addr_next = '0;
                status_next = ilff_pkg::ST_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT0;
            brk_reg <= 15'd4;
            limit_reg <= ilff_pkg::LIMIT_RESET;
            done_reg <= 1'b0;
            addr_reg <= '0;
            status_reg <= ilff_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            brk_reg <= brk_next;
            limit_reg <= limit_next;
            done_reg <= done_next;
            addr_reg <= addr_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        need_reg <= need_next;
        sz_reg <= sz_next;
        nw_reg <= nw_next;
        wa_reg <= wa_next;
        wv_reg <= wv_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result_address = addr_reg;
    assign status = status_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ilff_pkg::ST_OK) |-> result_address == 14'd0)
        else $error("failed item carries an address");

    a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("heap write while idle");

    a_brk_align: assert property (@(posedge clk) disable iff (!rst_n)
        brk_reg[1:0] == 2'd0)
        else $error("heap break not word aligned");

endmodule
